// ===== sv/u2o_pkg.sv =====
// ----------------------------------------------------------------------------
// u2o_pkg
// Shared types, codes and helpers of the UTF-8 to UTF-16 offset mapper.
// ----------------------------------------------------------------------------
package u2o_pkg;

   // fixed field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ANSWER_W = 20;
   localparam int unsigned TARGET_W = 20;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned POINT_W  = 21;
   localparam int unsigned LEN_W    = 3;

   // operating modes, the spare code MODE_TOTAL_ALT counts as total mode
   typedef enum logic [MODE_W-1:0] {
      MODE_TOTAL_UNITS  = 2'd0,
      MODE_UNITS_TO_POS = 2'd1,
      MODE_POS_FOR_UNIT = 2'd2,
      MODE_TOTAL_ALT    = 2'd3
   } mode_type;

   // register indexes of the csr port
   typedef enum logic {
      CSR_MODE   = 1'b0,
      CSR_TARGET = 1'b1
   } csr_index_type;

   // lead byte classes
   localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_MASK  = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD2_VAL   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_VAL   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_VAL   = 8'hF0;
   localparam logic [BYTE_W-1:0] BITS2_MASK  = 8'h1F;
   localparam logic [BYTE_W-1:0] BITS3_MASK  = 8'h0F;
   localparam logic [BYTE_W-1:0] BITS4_MASK  = 8'h07;
   localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;
   localparam logic [POINT_W-1:0] BMP_MAX    = 21'h00FFFF;

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   // sequence length from the lead byte, anything unknown is one byte
   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] len;
      len = LEN_ONE;
      if ((b & ASCII_MASK) == '0)             len = LEN_ONE;
      else if ((b & LEAD3_MASK) == LEAD2_VAL) len = LEN_TWO;
      else if ((b & LEAD4_MASK) == LEAD3_VAL) len = LEN_THREE;
      else if ((b & LEAD5_MASK) == LEAD4_VAL) len = LEN_FOUR;
      return len;
   endfunction

   // code point bits carried by a lead byte
   function automatic logic [POINT_W-1:0] lead_bits(input logic [BYTE_W-1:0] b);
      logic [POINT_W-1:0] bits;
      case (lead_length(b))
         LEN_TWO:   bits = POINT_W'(b & BITS2_MASK);
         LEN_THREE: bits = POINT_W'(b & BITS3_MASK);
         LEN_FOUR:  bits = POINT_W'(b & BITS4_MASK);
         default:   bits = POINT_W'(b);
      endcase
      return bits;
   endfunction

endpackage

// ===== sv/u2o_chan_if.sv =====
// ----------------------------------------------------------------------------
// u2o channel interfaces
// Valid/ready channels for the byte stream and for the answers.
// ----------------------------------------------------------------------------
interface u2o_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface u2o_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] answer;

   modport source (output valid, output answer, input ready);
   modport sink   (input valid, input answer, output ready);
endinterface

// ===== sv/u2o_piece.sv =====
// ----------------------------------------------------------------------------
// u2o_piece
// Applies one parsed piece (end offset and unit count) to the line counters.
// ----------------------------------------------------------------------------
module u2o_piece #(
   parameter int unsigned COUNT_BITS = 20
) (
   input  u2o_pkg::mode_type                 mode,
   input  logic [u2o_pkg::TARGET_W-1:0]      target,
   input  logic                              enable,
   input  logic [COUNT_BITS-1:0]             end_pos,
   input  logic                              two_units,
   input  logic [COUNT_BITS-1:0]             unit_in,
   input  logic [COUNT_BITS-1:0]             offset_in,
   input  logic                              stop_in,
   output logic [COUNT_BITS-1:0]             unit_out,
   output logic [COUNT_BITS-1:0]             offset_out,
   output logic                              stop_out
);
   import u2o_pkg::*;

   localparam int unsigned CMP_W = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;

   logic [COUNT_BITS:0]   sum_raw;
   logic [COUNT_BITS-1:0] sum_sat;
   logic [CMP_W-1:0]      target_w;
   logic [CMP_W-1:0]      end_w;
   logic [CMP_W-1:0]      unit_w;
   logic [CMP_W-1:0]      sum_w;

   // saturating unit add
   assign sum_raw = {1'b0, unit_in} + (two_units ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
   assign sum_sat = sum_raw[COUNT_BITS] ? '1 : sum_raw[COUNT_BITS-1:0];

   // compare at a common width
   assign target_w = CMP_W'(target);
   assign end_w    = CMP_W'(end_pos);
   assign unit_w   = CMP_W'(unit_in);
   assign sum_w    = CMP_W'(sum_sat);

   // per-mode limit handling
   always_comb begin
      unit_out   = unit_in;
      offset_out = offset_in;
      stop_out   = stop_in;
      if (enable) begin
         case (mode)
            MODE_UNITS_TO_POS: begin
               if (!stop_in) begin
                  if (end_w > target_w) stop_out = 1'b1;
                  else                  unit_out = sum_sat;
               end
            end
            MODE_POS_FOR_UNIT: begin
               if (!stop_in) begin
                  if (unit_w >= target_w) begin
                     stop_out = 1'b1;
                  end else begin
                     unit_out = sum_sat;
                     if (sum_w <= target_w) offset_out = end_pos;
                     else                   stop_out   = 1'b1;
                  end
               end
            end
            default: begin
               unit_out = sum_sat;
            end
         endcase
      end
   end

endmodule

// ===== sv/utf8_utf16_offset_mapper_core.sv =====
// ----------------------------------------------------------------------------
// utf8_utf16_offset_mapper_core
// Counts UTF-16 code units of a UTF-8 line, or maps between byte offsets
// and unit offsets, one byte per cycle unless a last byte waits on rsp_ch.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one byte of the line per transfer, with last on the final
//   byte. rsp_ch carries one answer per line, sent after the last byte.
//   csr_we/csr_index/csr_wdata write mode (index 0) and target (index 1);
//   write them only between lines while the block is idle.
// Timing:
//   one byte per cycle, unless a last byte waits on a stalled rsp_ch. Every
//   byte updates the sequence decoder and the counters in the cycle it is
//   taken; the answer is registered and appears on rsp_ch in the cycle after the last byte transfer.
//   Throughput is set by the single counter update path, which handles the
//   re-parse of a sequence cut off by the end of the line (up to three
//   pieces) in that same cycle.
// Stalls and reset:
//   while an answer waits on a stalled rsp_ch, bytes that are not last are
//   still taken; a last byte waits until the output register frees up.
//   Synchronous reset clears mode, target, line state and the output valid.
// ----------------------------------------------------------------------------
module utf8_utf16_offset_mapper_core #(
   parameter int unsigned COUNT_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   u2o_req_if.sink                              req_ch,
   u2o_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  u2o_pkg::csr_index_type               csr_index,
   input  logic [u2o_pkg::TARGET_W-1:0]         csr_wdata
);
   import u2o_pkg::*;

   localparam int unsigned CMP_W = (COUNT_BITS > ANSWER_W) ? COUNT_BITS : ANSWER_W;

   // configuration registers
   mode_type              mode_ff;
   logic [TARGET_W-1:0]   target_ff;

   // line state
   logic [LEN_W-1:0]      expected_ff, expected_in;
   logic [LEN_W-1:0]      seen_ff, seen_in;
   logic [POINT_W-1:0]    point_ff, point_in;
   logic [COUNT_BITS-1:0] start_ff, start_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [COUNT_BITS-1:0] unit_ff;
   logic [COUNT_BITS-1:0] mapped_ff;
   logic                  stopped_ff;
   logic                  second_two_ff, second_two_in;

   // result register
   logic                  rsp_valid_ff;
   logic [ANSWER_W-1:0]   answer_ff;

   logic                  out_free;
   logic                  take;
   logic [COUNT_BITS:0]   pos_raw;
   logic                  complete;
   logic [COUNT_BITS:0]   s1_raw, s2_raw, s3_raw;
   logic [COUNT_BITS-1:0] s1, s2, s3;

   // piece inputs
   logic                  p0_en, p1_en, p2_en;
   logic [COUNT_BITS-1:0] p0_end, p1_end, p2_end;
   logic                  p0_two;
   logic [COUNT_BITS-1:0] u0, u1, u2;
   logic [COUNT_BITS-1:0] m0, m1, m2;
   logic                  t0, t1, t2;
   logic [CMP_W-1:0]      answer_w;

   // handshake: only a last byte needs the output register
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = out_free || !req_ch.last;
   assign take         = req_ch.valid && req_ch.ready;

   // byte position, saturating
   assign pos_raw = {1'b0, pos_ff} + (COUNT_BITS+1)'(1);
   assign pos_in  = pos_raw[COUNT_BITS] ? '1 : pos_raw[COUNT_BITS-1:0];

   // sequence decoder
   always_comb begin
      expected_in   = expected_ff;
      seen_in       = seen_ff + LEN_W'(1);
      point_in      = {point_ff[POINT_W-7:0], req_ch.data_byte[5:0] & CONT_MASK[5:0]};
      start_in      = start_ff;
      second_two_in = second_two_ff;
      if (seen_ff == '0) begin
         expected_in = lead_length(req_ch.data_byte);
         seen_in     = LEN_ONE;
         point_in    = lead_bits(req_ch.data_byte);
         start_in    = pos_ff;
      end else if (seen_ff == LEN_ONE) begin
         second_two_in = (lead_length(req_ch.data_byte) == LEN_TWO);
      end
   end

   assign complete = (seen_in >= expected_in);

   // offsets for the re-parse of a cut-off sequence
   assign s1_raw = {1'b0, start_in} + (COUNT_BITS+1)'(1);
   assign s2_raw = {1'b0, start_in} + (COUNT_BITS+1)'(2);
   assign s3_raw = {1'b0, start_in} + (COUNT_BITS+1)'(3);
   assign s1     = s1_raw[COUNT_BITS] ? '1 : s1_raw[COUNT_BITS-1:0];
   assign s2     = s2_raw[COUNT_BITS] ? '1 : s2_raw[COUNT_BITS-1:0];
   assign s3     = s3_raw[COUNT_BITS] ? '1 : s3_raw[COUNT_BITS-1:0];

   // piece selection
   always_comb begin
      p0_en  = 1'b0;
      p1_en  = 1'b0;
      p2_en  = 1'b0;
      p0_end = pos_in;
      p1_end = s2;
      p2_end = s3;
      p0_two = 1'b0;
      if (complete) begin
         p0_en  = 1'b1;
         p0_two = (point_in > BMP_MAX);
      end else if (req_ch.last) begin
         p0_en  = 1'b1;
         p0_end = s1;
         if (seen_in == LEN_TWO) begin
            p1_en = 1'b1;
         end else if (seen_in == LEN_THREE) begin
            p1_en = 1'b1;
            if (second_two_in) begin
               p1_end = s3;
            end else begin
               p2_en = 1'b1;
            end
         end
      end
   end

   // counter update chain
   u2o_piece #(.COUNT_BITS(COUNT_BITS)) u_piece0 (
      .mode(mode_ff), .target(target_ff), .enable(p0_en), .end_pos(p0_end),
      .two_units(p0_two), .unit_in(unit_ff), .offset_in(mapped_ff),
      .stop_in(stopped_ff), .unit_out(u0), .offset_out(m0), .stop_out(t0)
   );

   u2o_piece #(.COUNT_BITS(COUNT_BITS)) u_piece1 (
      .mode(mode_ff), .target(target_ff), .enable(p1_en), .end_pos(p1_end),
      .two_units(1'b0), .unit_in(u0), .offset_in(m0),
      .stop_in(t0), .unit_out(u1), .offset_out(m1), .stop_out(t1)
   );

   u2o_piece #(.COUNT_BITS(COUNT_BITS)) u_piece2 (
      .mode(mode_ff), .target(target_ff), .enable(p2_en), .end_pos(p2_end),
      .two_units(1'b0), .unit_in(u1), .offset_in(m1),
      .stop_in(t1), .unit_out(u2), .offset_out(m2), .stop_out(t2)
   );

   // answer of the line
   assign answer_w = (mode_ff == MODE_POS_FOR_UNIT) ? CMP_W'(m2) : CMP_W'(u2);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TOTAL_UNITS;
         target_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_TARGET: target_ff <= csr_wdata;
            default:    target_ff <= target_ff;
         endcase
      end
   end

   // line state update
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= '0;
         seen_ff       <= '0;
         point_ff      <= '0;
         start_ff      <= '0;
         pos_ff        <= '0;
         unit_ff       <= '0;
         mapped_ff     <= '0;
         stopped_ff    <= 1'b0;
         second_two_ff <= 1'b0;
      end else if (take) begin
         if (req_ch.last) begin
            expected_ff   <= '0;
            seen_ff       <= '0;
            point_ff      <= '0;
            start_ff      <= '0;
            pos_ff        <= '0;
            unit_ff       <= '0;
            mapped_ff     <= '0;
            stopped_ff    <= 1'b0;
            second_two_ff <= 1'b0;
         end else begin
            pos_ff        <= pos_in;
            start_ff      <= start_in;
            second_two_ff <= second_two_in;
            unit_ff       <= u2;
            mapped_ff     <= m2;
            stopped_ff    <= t2;
            if (complete) begin
               expected_ff <= '0;
               seen_ff     <= '0;
               point_ff    <= '0;
            end else begin
               expected_ff <= expected_in;
               seen_ff     <= seen_in;
               point_ff    <= point_in;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_ch.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_ch.last) begin
         answer_ff <= answer_w[ANSWER_W-1:0];
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.answer = answer_ff;

endmodule

// ===== bench/utf8_utf16_offset_mapper_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_utf16_offset_mapper_core_tb
// Feeds UTF-8 lines byte by byte through the mapper and checks every answer.
// A directed table covers reset values, lead byte classes, cut-off sequences
// and the limits of each mode. Random lines follow, mostly well-formed text
// with broken and truncated sequences mixed in, over several mode/target
// settings. Answers are compared in order with a behavioral line decoder.
// ----------------------------------------------------------------------------
module utf8_utf16_offset_mapper_core_tb;
   import u2o_pkg::*;

   localparam int unsigned CLK_HALF    = 6;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RAND_BYTES  = 600;
   localparam int unsigned QUIET_FROM  = 520;
   localparam logic [19:0] COUNT_MAX   = 20'hFFFFF;
   localparam int unsigned N_DIRECTED  = 10;

   // one directed line: setting, up to five bytes, optional fixed answer
   typedef struct packed {
      mode_type          mode;
      logic [19:0]       target;
      logic [2:0]        count;
      logic [0:4][7:0]   text;
      logic              pinned;
      logic [19:0]       pinned_answer;
   } dir_line_type;

   localparam dir_line_type DIRECTED [N_DIRECTED] = '{
      // single ascii byte straight after reset
      '{MODE_TOTAL_UNITS,  20'd0, 3'd1, {8'h41, 32'h0}, 1'b1, 20'd1},
      // zero, invalid lead, stray continuation, top ascii
      '{MODE_TOTAL_UNITS,  20'd0, 3'd4, {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00},
        1'b1, 20'd4},
      // four byte sequence above the basic plane gives a pair
      '{MODE_TOTAL_UNITS,  20'd0, 3'd4, {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00},
        1'b1, 20'd2},
      // lone two byte lead cut off by end of line
      '{MODE_TOTAL_UNITS,  20'd0, 3'd1, {8'hC3, 32'h0}, 1'b1, 20'd1},
      // cut-off four byte lead whose second byte is a two byte lead
      '{MODE_TOTAL_UNITS,  20'd0, 3'd3, {8'hF0, 8'hC3, 8'hA9, 16'h0},
        1'b0, 20'd0},
      // byte limit zero stops before the first sequence
      '{MODE_UNITS_TO_POS, 20'd0, 3'd1, {8'h41, 32'h0}, 1'b1, 20'd0},
      // byte limit inside a three byte sequence
      '{MODE_UNITS_TO_POS, 20'd3, 3'd5, {8'h41, 8'hE2, 8'h82, 8'hAC, 8'h41},
        1'b0, 20'd0},
      // unit target that would split a pair
      '{MODE_POS_FOR_UNIT, 20'd1, 3'd5, {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41},
        1'b0, 20'd0},
      // largest unit target
      '{MODE_POS_FOR_UNIT, COUNT_MAX, 3'd1, {8'h41, 32'h0}, 1'b0, 20'd0},
      // spare mode code acts as total count
      '{MODE_TOTAL_ALT,    20'd0, 3'd1, {8'h41, 32'h0}, 1'b1, 20'd1}
   };

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [TARGET_W-1:0] csr_wdata;

   u2o_req_if req_ch ();
   u2o_rsp_if rsp_ch ();

   utf8_utf16_offset_mapper_core #(
      .COUNT_BITS (20)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies held by the line decoder
   mode_type    cfg_mode   = MODE_TOTAL_UNITS;
   logic [19:0] cfg_target = '0;

   // line decoder state
   logic [2:0]  ln_len     = '0;
   logic [2:0]  ln_seen    = '0;
   logic [20:0] ln_point   = '0;
   logic [19:0] ln_start   = '0;
   logic [19:0] ln_pos     = '0;
   logic [19:0] ln_units   = '0;
   logic [19:0] ln_offset  = '0;
   logic        ln_stopped = 1'b0;
   logic [7:0]  ln_second  = '0;

   logic [19:0] pending_answers[$];
   logic [7:0]  line_bytes[$];

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned answers_seen  = 0;
   int unsigned lines_sent    = 0;
   int unsigned bytes_sent    = 0;
   int unsigned settings_used = 0;
   int unsigned rsp_hold      = 0;
   bit          idle_on       = 1'b1;
   bit          quiet         = 1'b0;

   // clock
   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, pending_answers.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [19:0] got,
                                  input logic [19:0] want);
      mismatches++;
      $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   function automatic logic [19:0] sat_add(input logic [19:0] a,
                                           input logic [19:0] b);
      logic [20:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[20] ? COUNT_MAX : sum[19:0];
   endfunction

   // sequence length implied by a lead byte
   function automatic logic [2:0] seq_length(input logic [7:0] b);
      casez (b)
         8'b0???????: return 3'd1;
         8'b110?????: return 3'd2;
         8'b1110????: return 3'd3;
         8'b11110???: return 3'd4;
         default:     return 3'd1;
      endcase
   endfunction

   // account one parsed piece ending at byte offset stop_at
   function automatic void apply_piece(input logic [19:0] stop_at,
                                       input logic [19:0] units);
      case (cfg_mode)
         MODE_UNITS_TO_POS: begin
            if (!ln_stopped) begin
               if (stop_at > cfg_target) ln_stopped = 1'b1;
               else ln_units = sat_add(ln_units, units);
            end
         end
         MODE_POS_FOR_UNIT: begin
            if (!ln_stopped) begin
               if (ln_units >= cfg_target) begin
                  ln_stopped = 1'b1;
               end else begin
                  ln_units = sat_add(ln_units, units);
                  if (ln_units <= cfg_target) ln_offset = stop_at;
                  else ln_stopped = 1'b1;
               end
            end
         end
         default: ln_units = sat_add(ln_units, units);
      endcase
   endfunction

   // advance the line decoder by one byte, answer on the last byte
   function automatic void decode_byte(input logic [7:0] b, input logic is_last,
                                       output logic has_answer,
                                       output logic [19:0] answer);
      logic [19:0] pos;
      logic [19:0] base;
      has_answer = 1'b0;
      answer     = '0;
      pos        = ln_pos;
      ln_pos     = sat_add(pos, 20'd1);
      if (ln_seen == 3'd0) begin
         ln_start = pos;
         ln_len   = seq_length(b);
         ln_seen  = 3'd1;
         case (ln_len)
            3'd2:    ln_point = 21'(b[4:0]);
            3'd3:    ln_point = 21'(b[3:0]);
            3'd4:    ln_point = 21'(b[2:0]);
            default: ln_point = 21'(b);
         endcase
      end else begin
         if (ln_seen == 3'd1) ln_second = b;
         ln_point = {ln_point[14:0], b[5:0]};
         ln_seen  = ln_seen + 3'd1;
      end
      // complete sequence, or line cut off inside one
      if (ln_seen >= ln_len) begin
         apply_piece(ln_pos, (ln_point > 21'h00FFFF) ? 20'd2 : 20'd1);
         ln_seen  = '0;
         ln_len   = '0;
         ln_point = '0;
      end else if (is_last) begin
         base = ln_start;
         apply_piece(sat_add(base, 20'd1), 20'd1);
         if (ln_seen == 3'd2) begin
            apply_piece(sat_add(base, 20'd2), 20'd1);
         end else if (ln_seen == 3'd3) begin
            if (seq_length(ln_second) == 3'd2) begin
               apply_piece(sat_add(base, 20'd3), 20'd1);
            end else begin
               apply_piece(sat_add(base, 20'd2), 20'd1);
               apply_piece(sat_add(base, 20'd3), 20'd1);
            end
         end
      end
      // answer and start a fresh line
      if (is_last) begin
         has_answer = 1'b1;
         answer     = (cfg_mode == MODE_POS_FOR_UNIT) ? ln_offset : ln_units;
         ln_len     = '0;
         ln_seen    = '0;
         ln_point   = '0;
         ln_start   = '0;
         ln_pos     = '0;
         ln_units   = '0;
         ln_offset  = '0;
         ln_stopped = 1'b0;
         ln_second  = '0;
      end
   endfunction

   // continuation byte, now and then a corrupted one
   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 15) == 0) return 8'($urandom);
      return {2'b10, 6'($urandom)};
   endfunction

   // random line: mostly well-formed sequences, some noise, some cut-off ends
   function automatic void compose_line();
      int unsigned pieces;
      int unsigned kind;
      int unsigned held;
      line_bytes.delete();
      pieces = $urandom_range(1, 8);
      for (int p = 0; p < pieces; p++) begin
         kind = $urandom_range(0, 11);
         case (kind)
            0, 1, 2, 3: line_bytes.push_back(8'($urandom_range(0, 127)));
            4, 5: begin
               line_bytes.push_back({3'b110, 5'($urandom)});
               line_bytes.push_back(cont_byte());
            end
            6, 7: begin
               line_bytes.push_back({4'b1110, 4'($urandom)});
               repeat (2) line_bytes.push_back(cont_byte());
            end
            8, 9: begin
               line_bytes.push_back({5'b11110, 3'($urandom)});
               repeat (3) line_bytes.push_back(cont_byte());
            end
            10: line_bytes.push_back(8'($urandom));
            default: line_bytes.push_back({2'b10, 6'($urandom)});
         endcase
      end
      // end the line inside a multi-byte sequence
      if ($urandom_range(0, 3) == 0) begin
         kind = $urandom_range(2, 4);
         case (kind)
            2:       line_bytes.push_back({3'b110, 5'($urandom)});
            3:       line_bytes.push_back({4'b1110, 4'($urandom)});
            default: line_bytes.push_back({5'b11110, 3'($urandom)});
         endcase
         held = $urandom_range(0, kind - 2);
         for (int h = 0; h < held; h++) begin
            if (h == 0 && $urandom_range(0, 1) == 0)
               line_bytes.push_back({3'b110, 5'($urandom)});
            else
               line_bytes.push_back(8'($urandom));
         end
      end
   endfunction

   // one byte transfer; the answer is either pinned or from the decoder
   task automatic send_byte(input logic [7:0] b, input logic is_last,
                            input logic pinned, input logic [19:0] pinned_answer);
      logic        has_answer;
      logic [19:0] answer;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last      <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decode_byte(b, is_last, has_answer, answer);
      bytes_sent++;
      if (has_answer) begin
         pending_answers.push_back(pinned ? pinned_answer : answer);
         lines_sent++;
      end
   endtask

   // sender gap burst
   task automatic maybe_idle();
      if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending until every answer is back
   task automatic wait_for_answers();
      req_ch.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write mode then target while the block is idle
   task automatic program_config(input mode_type mode, input logic [19:0] target);
      wait_for_answers();
      csr_we    <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= TARGET_W'(mode);
      @(posedge clock);
      cfg_mode  = mode;
      csr_index <= CSR_TARGET;
      csr_wdata <= target;
      @(posedge clock);
      cfg_target = target;
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   // answer side: compare each transfer, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         answers_seen++;
         if (pending_answers.size() == 0)
            report_mismatch("answer with no line pending", rsp_ch.answer, '0);
         else if (rsp_ch.answer !== pending_answers[0])
            report_mismatch("answer", rsp_ch.answer, pending_answers.pop_front());
         else
            void'(pending_answers.pop_front());
      end
      if (!quiet && rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(1, 6) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // stimulus
   initial begin : stimulus
      dir_line_type row;
      mode_type     mode;
      logic [19:0]  target;
      int unsigned  rand_bytes;
      int unsigned  phase_bytes;
      int unsigned  phase;

      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_MODE;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last      = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, registers still at reset values for the first rows
      for (int r = 0; r < N_DIRECTED; r++) begin
         row = DIRECTED[r];
         if (row.mode != cfg_mode || row.target != cfg_target)
            program_config(row.mode, row.target);
         for (int i = 0; i < row.count; i++) begin
            send_byte(row.text[i], i == row.count - 1, row.pinned, row.pinned_answer);
            maybe_idle();
         end
      end

      // random lines over a series of settings, extremes first
      rand_bytes = 0;
      phase      = 0;
      while (rand_bytes < RAND_BYTES) begin
         case (phase)
            0: begin mode = MODE_UNITS_TO_POS; target = '0;        end
            1: begin mode = MODE_UNITS_TO_POS; target = COUNT_MAX; end
            2: begin mode = MODE_POS_FOR_UNIT; target = '0;        end
            3: begin mode = MODE_POS_FOR_UNIT; target = COUNT_MAX; end
            4: begin mode = MODE_TOTAL_UNITS;  target = COUNT_MAX; end
            default: begin
               mode = mode_type'(2'($urandom_range(0, 3)));
               case ($urandom_range(0, 5))
                  4:       target = COUNT_MAX;
                  5:       target = 20'($urandom);
                  default: target = 20'($urandom_range(0, 24));
               endcase
            end
         endcase
         program_config(mode, target);
         phase_bytes = 0;
         while (phase_bytes < 50) begin
            compose_line();
            quiet   = (rand_bytes >= QUIET_FROM);
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            foreach (line_bytes[i]) begin
               send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, '0);
               maybe_idle();
            end
            phase_bytes += line_bytes.size();
            rand_bytes  += line_bytes.size();
         end
         phase++;
      end

      // drain and let the output register settle
      wait_for_answers();
      repeat (8) @(posedge clock);

      $display("sent %0d lines, %0d bytes; compared %0d answers",
               lines_sent, bytes_sent, answers_seen);
      $display("visited %0d mode/target settings, %0d mismatches",
               settings_used, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
